[design/orf_pkg.sv]
// Shared types, constants and command codes of the overwriting ring FIFO.
package orf_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WIDTH_DEF = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_CLEAR = 2'd2
  } orf_cmd_e;

  // Decoded operation handed from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic put;
    logic get;
    logic clr;
  } orf_ctrl_t;

  // Result payload as driven by the datapath.
  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic               data_valid;
    logic               dropped_oldest;
    logic               is_empty;
    logic               is_full;
    logic [COUNT_W-1:0] fill_count;
  } orf_rsp_t;

endpackage

[design/orf_if.sv]
// Request and response channel interfaces of the overwriting ring FIFO.
interface orf_req_if;
  import orf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface orf_rsp_if;
  import orf_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_out;
  logic               data_valid;
  logic               dropped_oldest;
  logic               is_empty;
  logic               is_full;
  logic [COUNT_W-1:0] fill_count;

  modport source (output valid, output data_out, output data_valid, output dropped_oldest,
                  output is_empty, output is_full, output fill_count, input ready);
  modport sink   (input valid, input data_out, input data_valid, input dropped_oldest,
                  input is_empty, input is_full, input fill_count, output ready);
endinterface

[design/overwrite_ring_fifo.sv]
// Top level of the overwriting ring FIFO: controller, datapath and assertions.
//
//   channel   dir   handshake          payload
//   req_i     in    valid / ready      cmd, data_in
//   rsp_o     out   valid / ready      data_out, data_valid, dropped_oldest,
//                                      is_empty, is_full, fill_count
//
// Each request transaction yields its response in the cycle after acceptance,
// taken from the registered read port of the slot memory.
// A new request is accepted in the same cycle in which the previous response is
// taken, so one transaction per cycle is sustained while the consumer keeps up.
// A stall on rsp_o holds the response and blocks req_i until the response drains.
// Reset clears the pointers, the full flag and the handshake state; there is no
// clearing pass, since data_out is forced to zero unless a get returned a stored word.
module overwrite_ring_fifo #(
  parameter int unsigned DEPTH = orf_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = orf_pkg::WIDTH_DEF
) (
  input logic    clk_i,
  input logic    rst_ni,
  orf_req_if.sink   req_i,
  orf_rsp_if.source rsp_o
);
  import orf_pkg::*;

  orf_ctrl_t ctrl;
  orf_rsp_t  rsp;

  // The controller owns the handshake and decodes the command of each transaction.
  orf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .cmd_i       (req_i.cmd),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .ctrl_o      (ctrl)
  );

  // The datapath updates pointers and memory as each accepted transaction requires and
  // holds the response fields until the next one.
  orf_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .data_in_i (req_i.data_in),
    .rsp_o     (rsp)
  );

  assign rsp_o.data_out       = rsp.data_out;
  assign rsp_o.data_valid     = rsp.data_valid;
  assign rsp_o.dropped_oldest = rsp.dropped_oldest;
  assign rsp_o.is_empty       = rsp.is_empty;
  assign rsp_o.is_full        = rsp.is_full;
  assign rsp_o.fill_count     = rsp.fill_count;

  // A get from a full buffer always returns a stored word.
  a_get_full_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.cmd == CMD_GET && rsp.is_full)
      |=> rsp.data_valid)
    else $error("get from full buffer did not return a word");

  // A put into a full buffer drops the oldest entry and leaves the buffer full.
  a_put_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.cmd == CMD_PUT && rsp.is_full)
      |=> (rsp.dropped_oldest && rsp.is_full))
    else $error("put into full buffer did not drop the oldest entry");

  // A clear always leaves an empty buffer.
  a_clear_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.cmd == CMD_CLEAR) |=> rsp.is_empty)
    else $error("clear did not empty the buffer");

  // Empty and full never hold together.
  a_empty_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsp.is_empty && rsp.is_full))
    else $error("buffer reported both empty and full");

endmodule

[design/orf_ctrl.sv]
// Controller of the overwriting ring FIFO: handshake state machine and command decode.
module orf_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [orf_pkg::CMD_W-1:0] cmd_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output orf_pkg::orf_ctrl_t        ctrl_o
);
  import orf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_q, state_d;
  logic exec;

  // A new transaction is taken whenever the result register is free or drains now.
  assign in_ready_o  = (state_q == ST_IDLE) || out_ready_i;
  assign out_valid_o = (state_q == ST_HOLD);
  assign exec        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (exec) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready_i && !exec) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // An unknown command only reloads the result flags and changes no state.
  always_comb begin
    ctrl_o      = '0;
    ctrl_o.load = exec;
    unique case (cmd_i)
      CMD_PUT:   ctrl_o.put = exec;
      CMD_GET:   ctrl_o.get = exec;
      CMD_CLEAR: ctrl_o.clr = exec;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/orf_dp.sv]
// Datapath of the overwriting ring FIFO: slot memory, pointers, full flag and result register.
module orf_dp #(
  parameter int unsigned DEPTH = orf_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = orf_pkg::WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  orf_pkg::orf_ctrl_t         ctrl_i,
  input  logic [orf_pkg::DATA_W-1:0] data_in_i,
  output orf_pkg::orf_rsp_t          rsp_o
);
  import orf_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic             full_q, full_d;
  logic             valid_q, valid_d;
  logic             drop_q, drop_d;
  logic             empty_cur;
  logic [PW-1:0]    wr_adv, rd_adv;
  logic [63:0]      in_wide, out_wide;
  logic [WIDTH-1:0] wdata;
  logic [CW-1:0]    count;
  logic [31:0]      count_wide;

  assign wr_adv    = (wr_q == LAST) ? '0 : wr_q + PW'(1);
  assign rd_adv    = (rd_q == LAST) ? '0 : rd_q + PW'(1);
  assign empty_cur = !full_q && (wr_q == rd_q);
  assign in_wide   = 64'(data_in_i);
  assign wdata     = in_wide[WIDTH-1:0];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    full_d  = full_q;
    valid_d = valid_q;
    drop_d  = drop_q;
    if (ctrl_i.load) begin
      valid_d = 1'b0;
      drop_d  = 1'b0;
    end
    if (ctrl_i.put) begin
      wr_d   = wr_adv;
      drop_d = full_q;
      if (full_q) rd_d = rd_adv;
      full_d = (wr_adv == rd_d);
    end else if (ctrl_i.get) begin
      if (!empty_cur) begin
        valid_d = 1'b1;
        full_d  = 1'b0;
        rd_d    = rd_adv;
      end
    end else if (ctrl_i.clr) begin
      wr_d   = rd_q;
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.put) mem[wr_q] <= wdata;
    if (ctrl_i.load) rdata_q <= mem[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      full_q  <= 1'b0;
      valid_q <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      full_q  <= full_d;
      valid_q <= valid_d;
      drop_q  <= drop_d;
    end
  end

  // Status is taken from the pointers, which stay put until the next transaction.
  always_comb begin
    if (full_q) begin
      count = CW'(DEPTH);
    end else if (wr_q >= rd_q) begin
      count = CW'(wr_q) - CW'(rd_q);
    end else begin
      count = CW'(DEPTH) + CW'(wr_q) - CW'(rd_q);
    end
  end

  assign count_wide = 32'(count);
  assign out_wide   = 64'(rdata_q);

  assign rsp_o.data_out       = valid_q ? out_wide[DATA_W-1:0] : '0;
  assign rsp_o.data_valid     = valid_q;
  assign rsp_o.dropped_oldest = drop_q;
  assign rsp_o.is_empty       = empty_cur;
  assign rsp_o.is_full        = full_q;
  assign rsp_o.fill_count     = count_wide[COUNT_W-1:0];

endmodule
